// ===== sv/hcwu_pkg.sv =====
package hcwu_pkg;

	// Field and register widths
	localparam int unsigned RTT_W   = 16;
	localparam int unsigned WIN_W   = 32;
	localparam int unsigned RHO_W   = 16;
	localparam int unsigned CFG_W   = 16;
	localparam int unsigned CFG_IDX_W = 1;

	// Shared unit widths
	localparam int unsigned MUL_W   = 32;
	localparam int unsigned PROD_W  = 2 * MUL_W;
	localparam int unsigned DIV_W   = 32;
	localparam int unsigned STEP_W  = 6;

	// Fixed-point constants
	localparam int unsigned FRAC_W  = 30;
	localparam logic [RHO_W-1:0] RHO_ONE   = 16'd256;
	localparam logic [CFG_W-1:0] REF_RESET = 16'd50;
	localparam logic [CFG_W-1:0] SEG_RESET = 16'd536;
	localparam logic [30:0] ONE_Q30  = 31'd1073741824;
	localparam logic [63:0] HALF_Q30 = 64'd536870912;
	localparam logic [WIN_W-1:0] WIN_MAX = '1;

	// Divider step counts
	localparam logic [STEP_W-1:0] RHO_STEPS = 6'd24;
	localparam logic [STEP_W-1:0] CA_STEPS  = 6'd32;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_REF = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_SEG = 1'b1;

	typedef enum logic [1:0] {
		ACT_ACK  = 2'd0,
		ACT_LOAD = 2'd1,
		ACT_INIT = 2'd2,
		ACT_NONE = 2'd3
	} action_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_RHO_DIV,
		ST_RHO_WAIT,
		ST_BRANCH,
		ST_SS_FRAC,
		ST_SS_ACC,
		ST_SS_T,
		ST_SS_M1,
		ST_SS_M2,
		ST_SS_M3,
		ST_CA_M1,
		ST_CA_M2,
		ST_CA_M3,
		ST_CA_CHK,
		ST_CA_WAIT,
		ST_FINISH,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic             en;
		logic [MUL_W-1:0] a;
		logic [MUL_W-1:0] b;
	} mul_req_t;

	typedef struct packed {
		logic              start;
		logic [DIV_W-1:0]  rem_init;
		logic [DIV_W-1:0]  dividend;
		logic [DIV_W-1:0]  divisor;
		logic [STEP_W-1:0] steps;
	} div_req_t;

	// 2^(2^b/256) in Q30
	function automatic logic [MUL_W-1:0] frac_const(input logic [2:0] b);
		logic [MUL_W-1:0] c;
		unique case (b)
			3'd0: c = 32'd1076653033;
			3'd1: c = 32'd1079572136;
			3'd2: c = 32'd1085434106;
			3'd3: c = 32'd1097253708;
			3'd4: c = 32'd1121280436;
			3'd5: c = 32'd1170923762;
			3'd6: c = 32'd1276901417;
			3'd7: c = 32'd1518500250;
			default: c = 32'd1073741824;
		endcase
		return c;
	endfunction

endpackage

// ===== sv/hcwu_mul.sv =====
module hcwu_mul (
	input  logic                          clk,
	input  hcwu_pkg::mul_req_t            req,
	output logic [hcwu_pkg::PROD_W-1:0]   prod
);

	logic [hcwu_pkg::PROD_W-1:0] prod_q;

	// Registered 32x32 product
	always_ff @(posedge clk) begin
		if (req.en) begin
			prod_q <= {32'b0, req.a} * {32'b0, req.b};
		end
	end

	assign prod = prod_q;

endmodule

// ===== sv/hcwu_div.sv =====
module hcwu_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  hcwu_pkg::div_req_t           req,
	output logic                         busy,
	output logic [hcwu_pkg::DIV_W-1:0]   quot
);

	logic [hcwu_pkg::DIV_W-1:0]  rem_q;
	logic [hcwu_pkg::DIV_W-1:0]  dvd_q;
	logic [hcwu_pkg::DIV_W-1:0]  dvs_q;
	logic [hcwu_pkg::DIV_W-1:0]  quot_q;
	logic [hcwu_pkg::STEP_W-1:0] cnt_q;
	logic                        busy_q;

	logic [hcwu_pkg::DIV_W:0]    rem_sh;
	logic                        ge;
	logic [hcwu_pkg::DIV_W:0]    rem_sub;

	// One restoring step: shift in the next dividend bit, subtract if it fits
	always_comb begin
		rem_sh  = {rem_q, dvd_q[hcwu_pkg::DIV_W-1]};
		ge      = rem_sh >= {1'b0, dvs_q};
		rem_sub = rem_sh - {1'b0, dvs_q};
	end

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			cnt_q  <= req.steps;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == 6'd1) begin
				busy_q <= 1'b0;
			end
		end
	end

	// Data path
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q  <= req.rem_init;
			dvd_q  <= req.dividend;
			dvs_q  <= req.divisor;
			quot_q <= '0;
		end else if (busy_q) begin
			rem_q  <= ge ? rem_sub[hcwu_pkg::DIV_W-1:0] : rem_sh[hcwu_pkg::DIV_W-1:0];
			dvd_q  <= {dvd_q[hcwu_pkg::DIV_W-2:0], 1'b0};
			quot_q <= {quot_q[hcwu_pkg::DIV_W-2:0], ge};
		end
	end

	assign busy = busy_q;
	assign quot = quot_q;

	// Partial remainder stays below the divisor for the whole run
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> rem_q < dvs_q)
		else $error("divider remainder out of range");

	// A running divider never has a zero step count
	a_run_len: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> cnt_q != 6'd0)
		else $error("divider running with zero count");

endmodule

// ===== sv/hybla_congestion_window_update.sv =====
// Hybla congestion window update. Takes one event request at a time (ACK,
// load of window and threshold, or initialise) and returns one result with
// the new window, rho in Q8.8 and the slow start flag. Work runs through a
// small sequencer around one registered 32x32 multiplier and one radix-2
// divider. Load, unused and plain initialise events go straight to the
// result. An ACK in slow start takes an extra step per set fraction bit
// of rho, or skips the power steps when the increment saturates or the
// segment size is zero. In congestion avoidance it runs the divider,
// unless that quotient would overflow. A rho recompute (an ACK with a
// new lowest nonzero RTT, or an initialise with a nonzero RTT) runs the
// divider first. A full output register held off by the result side
// holds the sequencer in its last state. The input is stalled while
// an event is in progress; a finished result sits in an output register so
// the next request can be taken while it waits.
module hybla_congestion_window_update (
	input  logic                                  clk,
	input  logic                                  arst_n,

	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [hcwu_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [hcwu_pkg::CFG_W-1:0]            cfg_data,

	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic [1:0]                            action,
	input  logic [hcwu_pkg::RTT_W-1:0]            last_rtt_ms,
	input  logic [hcwu_pkg::RTT_W-1:0]            rtt_estimate_ms,
	input  logic [hcwu_pkg::WIN_W-1:0]            window_value,
	input  logic [hcwu_pkg::WIN_W-1:0]            threshold_value,

	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic [hcwu_pkg::WIN_W-1:0]            window_bytes,
	output logic [hcwu_pkg::RHO_W-1:0]            rho_q8_8,
	output logic                                  in_slow_start
);

	hcwu_pkg::state_t state_q, state_d;

	logic [hcwu_pkg::CFG_W-1:0] ref_q;
	logic [hcwu_pkg::CFG_W-1:0] seg_q;
	logic [hcwu_pkg::WIN_W-1:0] window_q;
	logic [hcwu_pkg::WIN_W-1:0] threshold_q;
	logic [hcwu_pkg::RTT_W-1:0] least_q;
	logic [hcwu_pkg::RHO_W-1:0] rho_q;

	hcwu_pkg::action_t          act_q;
	logic [hcwu_pkg::RTT_W-1:0] last_q;
	logic                       slow_q;
	logic [30:0]                p_q;
	logic [2:0]                 bit_q;
	logic [61:0]                t_q;
	logic [47:0]                acc_q;
	logic [hcwu_pkg::WIN_W-1:0] inc_q;

	logic                       out_valid_q;
	logic [hcwu_pkg::WIN_W-1:0] window_bytes_q;
	logic [hcwu_pkg::RHO_W-1:0] rho_out_q;
	logic                       slow_out_q;

	hcwu_pkg::mul_req_t         mul_req;
	logic [hcwu_pkg::PROD_W-1:0] prod;
	hcwu_pkg::div_req_t         div_req;
	logic                       div_busy;
	logic [hcwu_pkg::DIV_W-1:0] quot;

	logic                       in_acc;
	logic                       out_free;
	hcwu_pkg::action_t          act_in;
	logic [hcwu_pkg::RTT_W-1:0] rtt_sel;
	logic                       rtt_lower;
	logic                       slow_cond;
	logic                       frac_set;
	logic [47:0]                ca_num;
	logic [hcwu_pkg::WIN_W-1:0] ca_div;
	logic                       ca_sat;
	logic [hcwu_pkg::CFG_W-1:0] ref_eff;
	logic [hcwu_pkg::RHO_W-1:0] rho_new;
	logic [63:0]                p_rnd;
	logic [61:0]                t_new;
	logic [48:0]                ss_sum;
	logic [hcwu_pkg::WIN_W:0]   win_sum;
	logic [hcwu_pkg::WIN_W-1:0] win_sat;
	logic [hcwu_pkg::WIN_W-1:0] win_new;

	hcwu_mul u_mul (
		.clk  (clk),
		.req  (mul_req),
		.prod (prod)
	);

	hcwu_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.busy   (div_busy),
		.quot   (quot)
	);

	assign cfg_ready = 1'b1;
	assign in_acc    = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign act_in    = hcwu_pkg::action_t'(action);

	// Shared decode and arithmetic
	always_comb begin
		rtt_sel   = (last_rtt_ms != '0) ? last_rtt_ms : rtt_estimate_ms;
		rtt_lower = rtt_sel < least_q;
		slow_cond = window_q < threshold_q;
		frac_set  = rho_q[bit_q];
		ref_eff   = (ref_q == '0) ? 16'd1 : ref_q;

		// rho clamp to [1.0, 255.99]
		if (quot[23:16] != '0) begin
			rho_new = '1;
		end else if (quot[15:0] < hcwu_pkg::RHO_ONE) begin
			rho_new = hcwu_pkg::RHO_ONE;
		end else begin
			rho_new = quot[15:0];
		end

		p_rnd = prod + hcwu_pkg::HALF_Q30;
		t_new = ({31'b0, p_q} << rho_q[12:8]) - {31'b0, hcwu_pkg::ONE_Q30};
		ss_sum = {1'b0, acc_q} + {33'b0, prod[45:30]};

		ca_num = prod[63:16];
		ca_div = (window_q == '0) ? 32'd1 : window_q;
		ca_sat = {16'b0, ca_num[47:32]} >= ca_div;

		win_sum = {1'b0, window_q} + {1'b0, inc_q};
		win_sat = win_sum[hcwu_pkg::WIN_W] ? hcwu_pkg::WIN_MAX : win_sum[hcwu_pkg::WIN_W-1:0];
		win_new = (slow_q && (win_sat > threshold_q)) ? threshold_q : win_sat;
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			hcwu_pkg::ST_IDLE: begin
				if (in_acc) begin
					unique case (act_in)
						hcwu_pkg::ACT_ACK: begin
							state_d = (rtt_lower && (last_rtt_ms != '0)) ?
								hcwu_pkg::ST_RHO_DIV : hcwu_pkg::ST_BRANCH;
						end
						hcwu_pkg::ACT_INIT: begin
							state_d = (last_rtt_ms != '0) ?
								hcwu_pkg::ST_RHO_DIV : hcwu_pkg::ST_DONE;
						end
						default: state_d = hcwu_pkg::ST_DONE;
					endcase
				end
			end
			hcwu_pkg::ST_RHO_DIV: state_d = hcwu_pkg::ST_RHO_WAIT;
			hcwu_pkg::ST_RHO_WAIT: begin
				if (!div_busy) begin
					state_d = (act_q == hcwu_pkg::ACT_ACK) ?
						hcwu_pkg::ST_BRANCH : hcwu_pkg::ST_DONE;
				end
			end
			hcwu_pkg::ST_BRANCH: begin
				priority if (!slow_cond) begin
					state_d = hcwu_pkg::ST_CA_M1;
				end else if ((seg_q == '0) || (rho_q[15:13] != '0)) begin
					state_d = hcwu_pkg::ST_FINISH;
				end else begin
					state_d = hcwu_pkg::ST_SS_FRAC;
				end
			end
			hcwu_pkg::ST_SS_FRAC: begin
				if (frac_set) begin
					state_d = hcwu_pkg::ST_SS_ACC;
				end else if (bit_q == 3'd7) begin
					state_d = hcwu_pkg::ST_SS_T;
				end
			end
			hcwu_pkg::ST_SS_ACC: begin
				state_d = (bit_q == 3'd7) ? hcwu_pkg::ST_SS_T : hcwu_pkg::ST_SS_FRAC;
			end
			hcwu_pkg::ST_SS_T:  state_d = hcwu_pkg::ST_SS_M1;
			hcwu_pkg::ST_SS_M1: state_d = hcwu_pkg::ST_SS_M2;
			hcwu_pkg::ST_SS_M2: state_d = hcwu_pkg::ST_SS_M3;
			hcwu_pkg::ST_SS_M3: state_d = hcwu_pkg::ST_FINISH;
			hcwu_pkg::ST_CA_M1: state_d = hcwu_pkg::ST_CA_M2;
			hcwu_pkg::ST_CA_M2: state_d = hcwu_pkg::ST_CA_M3;
			hcwu_pkg::ST_CA_M3: state_d = hcwu_pkg::ST_CA_CHK;
			hcwu_pkg::ST_CA_CHK: begin
				state_d = ca_sat ? hcwu_pkg::ST_FINISH : hcwu_pkg::ST_CA_WAIT;
			end
			hcwu_pkg::ST_CA_WAIT: begin
				if (!div_busy) begin
					state_d = hcwu_pkg::ST_FINISH;
				end
			end
			hcwu_pkg::ST_FINISH: state_d = hcwu_pkg::ST_DONE;
			hcwu_pkg::ST_DONE: begin
				if (out_free) begin
					state_d = hcwu_pkg::ST_IDLE;
				end
			end
			default: state_d = hcwu_pkg::ST_IDLE;
		endcase
	end

	// Sequencer outputs: stall and shared unit requests
	always_comb begin
		in_stall         = (state_q != hcwu_pkg::ST_IDLE);
		mul_req          = '0;
		div_req          = '0;
		unique case (state_q)
			hcwu_pkg::ST_RHO_DIV: begin
				div_req.start    = 1'b1;
				div_req.rem_init = '0;
				div_req.dividend = {last_q, 16'b0};
				div_req.divisor  = {16'b0, ref_eff};
				div_req.steps    = hcwu_pkg::RHO_STEPS;
			end
			hcwu_pkg::ST_SS_FRAC: begin
				mul_req.en = frac_set;
				mul_req.a  = {1'b0, p_q};
				mul_req.b  = hcwu_pkg::frac_const(bit_q);
			end
			hcwu_pkg::ST_SS_M1: begin
				mul_req.en = 1'b1;
				mul_req.a  = t_q[61:30];
				mul_req.b  = {16'b0, seg_q};
			end
			hcwu_pkg::ST_SS_M2: begin
				mul_req.en = 1'b1;
				mul_req.a  = {2'b0, t_q[29:0]};
				mul_req.b  = {16'b0, seg_q};
			end
			hcwu_pkg::ST_CA_M1: begin
				mul_req.en = 1'b1;
				mul_req.a  = {16'b0, rho_q};
				mul_req.b  = {16'b0, rho_q};
			end
			hcwu_pkg::ST_CA_M2: begin
				mul_req.en = 1'b1;
				mul_req.a  = {16'b0, seg_q};
				mul_req.b  = {16'b0, seg_q};
			end
			hcwu_pkg::ST_CA_M3: begin
				mul_req.en = 1'b1;
				mul_req.a  = acc_q[31:0];
				mul_req.b  = prod[31:0];
			end
			hcwu_pkg::ST_CA_CHK: begin
				div_req.start    = !ca_sat;
				div_req.rem_init = {16'b0, ca_num[47:32]};
				div_req.dividend = ca_num[31:0];
				div_req.divisor  = ca_div;
				div_req.steps    = hcwu_pkg::CA_STEPS;
			end
			default: begin
			end
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= hcwu_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_q <= hcwu_pkg::REF_RESET;
			seg_q <= hcwu_pkg::SEG_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				hcwu_pkg::CFG_REF: ref_q <= cfg_data;
				hcwu_pkg::CFG_SEG: seg_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Congestion state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q    <= '0;
			threshold_q <= '1;
			least_q     <= '1;
			rho_q       <= hcwu_pkg::RHO_ONE;
			slow_q      <= 1'b0;
		end else begin
			unique case (state_q)
				hcwu_pkg::ST_IDLE: begin
					if (in_acc) begin
						slow_q <= 1'b0;
						unique case (act_in)
							hcwu_pkg::ACT_ACK: begin
								if (rtt_lower) begin
									least_q <= rtt_sel;
								end
							end
							hcwu_pkg::ACT_LOAD: begin
								window_q    <= window_value;
								threshold_q <= threshold_value;
							end
							hcwu_pkg::ACT_INIT: begin
								least_q  <= rtt_estimate_ms;
								window_q <= window_value;
							end
							default: begin
							end
						endcase
					end
				end
				hcwu_pkg::ST_RHO_WAIT: begin
					if (!div_busy) begin
						rho_q <= rho_new;
					end
				end
				hcwu_pkg::ST_BRANCH: slow_q <= slow_cond;
				hcwu_pkg::ST_FINISH: window_q <= win_new;
				default: begin
				end
			endcase
		end
	end

	// Working registers of one event
	always_ff @(posedge clk) begin
		unique case (state_q)
			hcwu_pkg::ST_IDLE: begin
				if (in_acc) begin
					act_q  <= act_in;
					last_q <= last_rtt_ms;
				end
			end
			hcwu_pkg::ST_BRANCH: begin
				p_q   <= hcwu_pkg::ONE_Q30;
				bit_q <= '0;
				if (seg_q == '0) begin
					inc_q <= '0;
				end else begin
					inc_q <= hcwu_pkg::WIN_MAX;
				end
			end
			hcwu_pkg::ST_SS_FRAC: begin
				if (!frac_set && (bit_q != 3'd7)) begin
					bit_q <= bit_q + 3'd1;
				end
			end
			hcwu_pkg::ST_SS_ACC: begin
				p_q <= p_rnd[60:30];
				if (bit_q != 3'd7) begin
					bit_q <= bit_q + 3'd1;
				end
			end
			hcwu_pkg::ST_SS_T:  t_q <= t_new;
			hcwu_pkg::ST_SS_M2: acc_q <= prod[47:0];
			hcwu_pkg::ST_SS_M3: begin
				inc_q <= (ss_sum[48:32] != '0) ? hcwu_pkg::WIN_MAX : ss_sum[31:0];
			end
			hcwu_pkg::ST_CA_M2: acc_q <= prod[47:0];
			hcwu_pkg::ST_CA_CHK: begin
				if (ca_sat) begin
					inc_q <= hcwu_pkg::WIN_MAX;
				end
			end
			hcwu_pkg::ST_CA_WAIT: begin
				if (!div_busy) begin
					inc_q <= quot;
				end
			end
			default: begin
			end
		endcase
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == hcwu_pkg::ST_DONE) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == hcwu_pkg::ST_DONE) && out_free) begin
			window_bytes_q <= window_q;
			rho_out_q      <= rho_q;
			slow_out_q     <= slow_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign window_bytes  = window_bytes_q;
	assign rho_q8_8      = rho_out_q;
	assign in_slow_start = slow_out_q;

	// Slow start never leaves the window above the threshold
	a_ss_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == hcwu_pkg::ST_FINISH && slow_q) |=> window_q <= threshold_q)
		else $error("slow start window above threshold");

	// rho never drops below 1.0
	a_rho_min: assert property (@(posedge clk) disable iff (!arst_n)
		rho_q >= hcwu_pkg::RHO_ONE)
		else $error("rho below one");

	// An accepted ACK keeps the input stalled on the next cycle
	a_ack_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && act_in == hcwu_pkg::ACT_ACK) |=> in_stall)
		else $error("ACK did not occupy the sequencer");

	// The slow start flag is only reported for an ACK
	a_slow_ack: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == hcwu_pkg::ST_DONE && slow_q) |-> act_q == hcwu_pkg::ACT_ACK)
		else $error("slow start flag on a non-ACK event");

endmodule

// ===== dv/hcwu_checker.sv =====
// Watches the register, request and result channels of the window update
// block, keeps its own copy of the congestion state and compares every
// result against the oldest outstanding prediction.
module hcwu_checker (
	input  logic                           clk,
	input  logic                           arst_n,

	input  logic                           cfg_valid,
	input  logic                           cfg_ready,
	input  logic [hcwu_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [hcwu_pkg::CFG_W-1:0]     cfg_data,

	input  logic                           in_valid,
	input  logic                           in_stall,
	input  logic [1:0]                     action,
	input  logic [hcwu_pkg::RTT_W-1:0]     last_rtt_ms,
	input  logic [hcwu_pkg::RTT_W-1:0]     rtt_estimate_ms,
	input  logic [hcwu_pkg::WIN_W-1:0]     window_value,
	input  logic [hcwu_pkg::WIN_W-1:0]     threshold_value,

	input  logic                           out_valid,
	input  logic                           out_stall,
	input  logic [hcwu_pkg::WIN_W-1:0]     window_bytes,
	input  logic [hcwu_pkg::RHO_W-1:0]     rho_q8_8,
	input  logic                           in_slow_start,

	output int                             mismatches,
	output int                             outstanding,
	output int                             slow_acks,
	output int                             avoid_acks
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [hcwu_pkg::WIN_W-1:0] window;
		logic [hcwu_pkg::RHO_W-1:0] rho;
		logic                       slow;
	} window_update_t;

	// 2^(2^b/256) in Q30, entry b
	localparam logic [7:0][31:0] EXP2_FRAC_Q30 = {
		32'd1518500250, 32'd1276901417, 32'd1170923762, 32'd1121280436,
		32'd1097253708, 32'd1085434106, 32'd1079572136, 32'd1076653033
	};
	localparam logic [63:0] Q30_UNIT   = 64'd1 << 30;
	localparam logic [63:0] Q30_ROUND  = 64'd1 << 29;
	localparam logic [63:0] Q30_MASK   = Q30_UNIT - 64'd1;
	localparam logic [63:0] WINDOW_CAP = 64'h0000_0000_FFFF_FFFF;

	// Shadow of the block's registers and state
	logic [hcwu_pkg::CFG_W-1:0] ref_ms;
	logic [hcwu_pkg::CFG_W-1:0] seg_len;
	logic [hcwu_pkg::WIN_W-1:0] cur_window;
	logic [hcwu_pkg::WIN_W-1:0] cur_threshold;
	logic [hcwu_pkg::RTT_W-1:0] cur_least_rtt;
	logic [hcwu_pkg::RHO_W-1:0] cur_rho;

	window_update_t pending_q[$];

	function automatic logic [63:0] cap_window(input logic [63:0] s);
		return (s > WINDOW_CAP) ? WINDOW_CAP : s;
	endfunction

	// rho = rtt / reference in Q8.8, held between 1.0 and full scale
	function automatic logic [hcwu_pkg::RHO_W-1:0] rho_for_rtt(
		input logic [hcwu_pkg::RTT_W-1:0] rtt);
		logic [63:0] q;
		q = {40'd0, rtt, 8'd0} / ((ref_ms == '0) ? 64'd1 : {48'd0, ref_ms});
		if (q < 64'd256)
			q = 64'd256;
		if (q > 64'd65535)
			q = 64'd65535;
		return q[hcwu_pkg::RHO_W-1:0];
	endfunction

	// segment * (2^rho - 1), power split into integer shift and fraction bits
	function automatic logic [63:0] slow_start_gain();
		logic [63:0] p;
		logic [63:0] t;
		logic [63:0] seg;
		int unsigned ip;
		int b;
		seg = {48'd0, seg_len};
		ip = {24'd0, cur_rho[15:8]};
		if (seg == 64'd0)
			return 64'd0;
		if (ip >= 32)
			return WINDOW_CAP;
		p = Q30_UNIT;
		for (b = 0; b < 8; b++)
			if (cur_rho[b])
				p = (p * {32'd0, EXP2_FRAC_Q30[b]} + Q30_ROUND) >> 30;
		t = (p << ip) - Q30_UNIT;
		return cap_window((t >> 30) * seg + (((t & Q30_MASK) * seg) >> 30));
	endfunction

	// segment^2 * rho^2 / window, rho^2 in Q16.16
	function automatic logic [63:0] avoidance_gain();
		logic [63:0] seg;
		logic [63:0] num;
		logic [63:0] div;
		seg = {48'd0, seg_len};
		num = seg * seg * ({48'd0, cur_rho} * {48'd0, cur_rho});
		div = (cur_window == '0) ? 64'd1 : {32'd0, cur_window};
		return cap_window((num >> 16) / div);
	endfunction

	always @(posedge clk or negedge arst_n) begin : monitor
		logic [hcwu_pkg::RTT_W-1:0] rtt;
		logic [63:0] grown;
		window_update_t want;
		if (!arst_n) begin
			ref_ms = hcwu_pkg::REF_RESET;
			seg_len = hcwu_pkg::SEG_RESET;
			cur_window = '0;
			cur_threshold = '1;
			cur_least_rtt = '1;
			cur_rho = hcwu_pkg::RHO_ONE;
			pending_q.delete();
			mismatches = 0;
			slow_acks = 0;
			avoid_acks = 0;
			outstanding <= 0;
		end else begin
			// register writes
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					hcwu_pkg::CFG_REF: ref_ms = cfg_data;
					hcwu_pkg::CFG_SEG: seg_len = cfg_data;
					default: ;
				endcase
			end

			// results against the oldest prediction
			if (out_valid && !out_stall) begin
				if (pending_q.size() == 0) begin
					$error("result with no request outstanding: window_bytes %0d rho_q8_8 %0d",
						window_bytes, rho_q8_8);
					mismatches++;
				end else begin
					want = pending_q.pop_front();
					if (window_bytes !== want.window) begin
						$error("window_bytes: expected %0d, actual %0d", want.window, window_bytes);
						mismatches++;
					end
					if (rho_q8_8 !== want.rho) begin
						$error("rho_q8_8: expected %0d, actual %0d", want.rho, rho_q8_8);
						mismatches++;
					end
					if (in_slow_start !== want.slow) begin
						$error("in_slow_start: expected %0d, actual %0d", want.slow, in_slow_start);
						mismatches++;
					end
				end
			end

			// accepted request: advance the shadow state
			if (in_valid && !in_stall) begin
				want.slow = 1'b0;
				case (hcwu_pkg::action_t'(action))
					hcwu_pkg::ACT_ACK: begin
						rtt = (last_rtt_ms != '0) ? last_rtt_ms : rtt_estimate_ms;
						if (rtt < cur_least_rtt) begin
							// only a real sample moves rho
							if (last_rtt_ms != '0)
								cur_rho = rho_for_rtt(last_rtt_ms);
							cur_least_rtt = rtt;
						end
						if (cur_window < cur_threshold) begin
							want.slow = 1'b1;
							slow_acks++;
							grown = cap_window({32'd0, cur_window} + slow_start_gain());
							if (grown > {32'd0, cur_threshold})
								grown = {32'd0, cur_threshold};
						end else begin
							avoid_acks++;
							grown = cap_window({32'd0, cur_window} + avoidance_gain());
						end
						cur_window = grown[hcwu_pkg::WIN_W-1:0];
					end
					hcwu_pkg::ACT_LOAD: begin
						cur_window = window_value;
						cur_threshold = threshold_value;
					end
					hcwu_pkg::ACT_INIT: begin
						if (last_rtt_ms != '0)
							cur_rho = rho_for_rtt(last_rtt_ms);
						cur_least_rtt = rtt_estimate_ms;
						cur_window = window_value;
					end
					hcwu_pkg::ACT_NONE: ;
					default: ;
				endcase
				want.window = cur_window;
				want.rho = cur_rho;
				pending_q.push_back(want);
			end

			outstanding <= pending_q.size();
		end
	end

endmodule

// ===== dv/tb_hybla_congestion_window_update.sv =====
// Stimulus and verdict for the window update block; all checking sits in
// hcwu_checker beside the block.
module tb_hybla_congestion_window_update;
	timeunit 1ns;
	timeprecision 1ps;

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;

	logic                           cfg_valid = 1'b0;
	logic                           cfg_ready;
	logic [hcwu_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [hcwu_pkg::CFG_W-1:0]     cfg_data = '0;

	logic                           in_valid = 1'b0;
	logic                           in_stall;
	logic [1:0]                     action = '0;
	logic [hcwu_pkg::RTT_W-1:0]     last_rtt_ms = '0;
	logic [hcwu_pkg::RTT_W-1:0]     rtt_estimate_ms = '0;
	logic [hcwu_pkg::WIN_W-1:0]     window_value = '0;
	logic [hcwu_pkg::WIN_W-1:0]     threshold_value = '0;

	logic                           out_valid;
	logic                           out_stall = 1'b0;
	logic [hcwu_pkg::WIN_W-1:0]     window_bytes;
	logic [hcwu_pkg::RHO_W-1:0]     rho_q8_8;
	logic                           in_slow_start;

	int mismatches;
	int outstanding;
	int slow_acks;
	int avoid_acks;

	int requests_sent = 0;
	int settings_used = 0;
	bit calm = 1'b0;
	bit hold_req = 1'b0;
	bit hold_taken = 1'b0;
	int hold_left = 0;

	always #4 clk = ~clk;

	hybla_congestion_window_update dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.action          (action),
		.last_rtt_ms     (last_rtt_ms),
		.rtt_estimate_ms (rtt_estimate_ms),
		.window_value    (window_value),
		.threshold_value (threshold_value),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.window_bytes    (window_bytes),
		.rho_q8_8        (rho_q8_8),
		.in_slow_start   (in_slow_start)
	);

	hcwu_checker window_check (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.action          (action),
		.last_rtt_ms     (last_rtt_ms),
		.rtt_estimate_ms (rtt_estimate_ms),
		.window_value    (window_value),
		.threshold_value (threshold_value),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.window_bytes    (window_bytes),
		.rho_q8_8        (rho_q8_8),
		.in_slow_start   (in_slow_start),
		.mismatches      (mismatches),
		.outstanding     (outstanding),
		.slow_acks       (slow_acks),
		.avoid_acks      (avoid_acks)
	);

	// Result side: random stalls, plus one long hold-off when asked
	always @(posedge clk) begin
		if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else if (hold_req && !hold_taken) begin
			hold_taken <= 1'b1;
			hold_left <= 400;
			out_stall <= 1'b1;
		end else begin
			out_stall <= !calm && ($urandom_range(99) < 10);
		end
	end

	function automatic logic [hcwu_pkg::RTT_W-1:0] clamp_rtt(input int v);
		return (v > 65535) ? 16'hFFFF : 16'(v);
	endfunction

	function automatic logic [hcwu_pkg::RTT_W-1:0] random_rtt();
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 15)
			return '0;
		if (pick < 60)
			return 16'($urandom_range(1, 400));
		if (pick < 80)
			return 16'($urandom_range(1, 5000));
		return 16'($urandom);
	endfunction

	function automatic logic [hcwu_pkg::WIN_W-1:0] random_window();
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 10)
			return '0;
		if (pick < 50)
			return 32'($urandom_range(0, 200000));
		if (pick < 75)
			return 32'($urandom);
		return 32'hFFFF_FFFF - 32'($urandom_range(0, 200000));
	endfunction

	// One event request; returns at the edge that accepts it
	task automatic send_request(input hcwu_pkg::action_t act,
		input logic [hcwu_pkg::RTT_W-1:0] last, input logic [hcwu_pkg::RTT_W-1:0] est,
		input logic [hcwu_pkg::WIN_W-1:0] wv, input logic [hcwu_pkg::WIN_W-1:0] tv);
		if (!calm && $urandom_range(99) < 10) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		in_valid <= 1'b1;
		action <= act;
		last_rtt_ms <= last;
		rtt_estimate_ms <= est;
		window_value <= wv;
		threshold_value <= tv;
		do @(posedge clk); while (in_stall);
		requests_sent++;
	endtask

	// Stop offering and wait for every predicted result
	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_config(input logic [hcwu_pkg::CFG_W-1:0] ref_set,
		input logic [hcwu_pkg::CFG_W-1:0] seg_set);
		cfg_valid <= 1'b1;
		cfg_index <= hcwu_pkg::CFG_REF;
		cfg_data <= ref_set;
		do @(posedge clk); while (!cfg_ready);
		cfg_index <= hcwu_pkg::CFG_SEG;
		cfg_data <= seg_set;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		settings_used++;
	endtask

	// Connection life: initialise, maybe load, then a run of ACKs whose RTT
	// drifts down now and then so the minimum and rho keep moving
	task automatic run_episode();
		int base;
		int n;
		logic [hcwu_pkg::RTT_W-1:0] last;
		base = $urandom_range(1, 3000);
		if ($urandom_range(3) == 0)
			base = $urandom_range(1, 65535);
		send_request(hcwu_pkg::ACT_INIT,
			($urandom_range(9) == 0) ? 16'd0 : clamp_rtt(base),
			16'($urandom), random_window(), random_window());
		if ($urandom_range(9) < 6)
			send_request(hcwu_pkg::ACT_LOAD, random_rtt(), random_rtt(),
				32'($urandom_range(0, 50000)), random_window());
		n = $urandom_range(4, 24);
		repeat (n) begin
			if ($urandom_range(4) == 0)
				base -= $urandom_range(0, base / 4);
			last = ($urandom_range(99) < 12) ? 16'd0 : clamp_rtt(base + $urandom_range(0, 40));
			send_request(hcwu_pkg::ACT_ACK, last, clamp_rtt(base + $urandom_range(0, 100)),
				random_window(), random_window());
		end
	endtask

	task automatic run_phase(input logic [hcwu_pkg::CFG_W-1:0] ref_set,
		input logic [hcwu_pkg::CFG_W-1:0] seg_set,
		input int items, input bit quiet, input bit with_hold);
		int first;
		write_config(ref_set, seg_set);
		calm <= quiet;
		first = requests_sent;
		while (requests_sent - first < items) begin
			if (with_hold && requests_sent - first >= items / 2)
				hold_req <= 1'b1;
			// stray requests of any kind, including the unused code
			if ($urandom_range(99) < 12)
				send_request(hcwu_pkg::action_t'($urandom_range(3)), random_rtt(),
					random_rtt(), random_window(), random_window());
			else
				run_episode();
		end
		drain();
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed requests at the reset register values
		send_request(hcwu_pkg::ACT_ACK, 16'd0, 16'd0, 32'd0, 32'd0);
		send_request(hcwu_pkg::ACT_INIT, 16'hFFFF, 16'hFFFF, 32'd0, 32'd0);
		send_request(hcwu_pkg::ACT_ACK, 16'd0, 16'd100, 32'd0, 32'd0);
		send_request(hcwu_pkg::ACT_ACK, 16'hFFFF, 16'd0, 32'd0, 32'd0);
		send_request(hcwu_pkg::ACT_LOAD, 16'd0, 16'd0, 32'd0, 32'd0);
		send_request(hcwu_pkg::ACT_ACK, 16'd200, 16'd200, 32'd0, 32'd0);
		send_request(hcwu_pkg::ACT_INIT, 16'd50, 16'd50, 32'd1000, 32'hFFFF_FFFF);
		send_request(hcwu_pkg::ACT_LOAD, 16'd0, 16'd0, 32'd1000, 32'd5000);
		send_request(hcwu_pkg::ACT_ACK, 16'd40, 16'd60, 32'd0, 32'd0);
		send_request(hcwu_pkg::ACT_INIT, 16'd75, 16'hFFFF, 32'd2000, 32'd0);
		send_request(hcwu_pkg::ACT_ACK, 16'd0, 16'd70, 32'd0, 32'd0);
		send_request(hcwu_pkg::ACT_INIT, 16'd1, 16'd1, 32'd10, 32'd0);
		send_request(hcwu_pkg::ACT_ACK, 16'd1, 16'd0, 32'd0, 32'd0);
		send_request(hcwu_pkg::ACT_INIT, 16'd12345, 16'd0, 32'd0, 32'd0);
		send_request(hcwu_pkg::ACT_LOAD, 16'd0, 16'd0, 32'hFFFF_FFF0, 32'hFFFF_FFFF);
		send_request(hcwu_pkg::ACT_ACK, 16'd0, 16'hFFFF, 32'd0, 32'd0);
		send_request(hcwu_pkg::ACT_NONE, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_request(hcwu_pkg::ACT_LOAD, 16'd0, 16'd0, 32'hFFFF_FFFF, 32'd0);
		send_request(hcwu_pkg::ACT_ACK, 16'd0, 16'd0, 32'd0, 32'd0);
		send_request(hcwu_pkg::ACT_INIT, 16'd0, 16'd300, 32'd123456, 32'd0);
		send_request(hcwu_pkg::ACT_LOAD, 16'd0, 16'd0, 32'd100, 32'd100000);
		send_request(hcwu_pkg::ACT_ACK, 16'd300, 16'd300, 32'd0, 32'd0);
		send_request(hcwu_pkg::ACT_ACK, 16'd299, 16'd300, 32'd0, 32'd0);
		send_request(hcwu_pkg::ACT_ACK, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		drain();

		// random phases over register extremes, zeros and typical values
		run_phase(16'd1, 16'hFFFF, 240, 1'b0, 1'b0);
		run_phase(16'hFFFF, 16'd1, 240, 1'b0, 1'b0);
		run_phase(16'd0, 16'd0, 200, 1'b0, 1'b0);
		run_phase(16'd257, 16'd1460, 250, 1'b0, 1'b1);
		run_phase(16'($urandom_range(1, 400)), 16'($urandom_range(1, 65535)), 240, 1'b0, 1'b0);
		run_phase(hcwu_pkg::REF_RESET, hcwu_pkg::SEG_RESET, 260, 1'b1, 1'b0);

		repeat (100) @(posedge clk);
		$display("Covered %0d event requests over %0d register settings incl. zero and full scale.",
			requests_sent, settings_used + 1);
		$display("ACKs: %0d slow start, %0d congestion avoidance; %0d mismatches.",
			slow_acks, avoid_acks, mismatches);
		if (mismatches == 0 && outstanding == 0)
			$display("[hybla_congestion_window_update] OK");
		else
			$display("[hybla_congestion_window_update] ERROR");
		$finish;
	end

	// Watchdog
	initial begin
		#10ms;
		$display("[hybla_congestion_window_update] ERROR");
		$finish;
	end

endmodule
